// ===== src/relr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RELR relocation decoder.
// No dependencies; every other file refers to this package by scoped names.
package relr_pkg;

	// Fixed widths of the channel payloads
	localparam int unsigned WORD_W = 64;

	// Defaults for the top-level parameters
	localparam int unsigned XLEN_DEFAULT       = 64;
	localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

	// Kind of a queued entry, taken from bit 0 of the RELR word
	typedef enum logic {
		ENT_ADDR   = 1'b0,
		ENT_BITMAP = 1'b1
	} entry_kind_t;

	// One classified entry between front and back
	typedef struct packed {
		entry_kind_t       kind;
		logic [WORD_W-1:0] value;  // relocated address, or bitmap bits shifted down
		logic              last;   // end of table
	} q_entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} back_state_t;

endpackage

// ===== src/relr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one RELR table entry per request.
// Uses relr_pkg for the payload width.
interface relr_in_if;
	logic                       valid;
	logic                       ready;
	logic [relr_pkg::WORD_W-1:0] relr_word;
	logic                       end_of_table;

	modport source (output valid, relr_word, end_of_table, input ready);
	modport sink (input valid, relr_word, end_of_table, output ready);
endinterface

// ===== src/relr_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one address to patch per request.
// Uses relr_pkg for the payload width.
interface relr_out_if;
	logic                       valid;
	logic                       ready;
	logic [relr_pkg::WORD_W-1:0] patch_address;
	logic                       last_of_run;

	modport source (output valid, patch_address, last_of_run, input ready);
	modport sink (input valid, patch_address, last_of_run, output ready);
endinterface

// ===== src/relr_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the load offset.
// Uses relr_pkg for the payload width.
interface relr_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [relr_pkg::WORD_W-1:0] load_offset;

	modport source (output valid, load_offset, input ready);
	modport sink (input valid, load_offset, output ready);
endinterface

// ===== src/relr_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the load offset, accepts RELR words and classifies them.
// Depends on relr_pkg and the relr_in_if / relr_cfg_if interfaces.
module relr_front #(
	parameter int unsigned XLEN = relr_pkg::XLEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	relr_in_if.sink             relr_in,
	relr_cfg_if.sink            cfg,
	input  relr_pkg::q_stat_t   q_stat,
	output logic                push,
	output relr_pkg::q_entry_t  push_data
);

	localparam logic [relr_pkg::WORD_W-1:0] WORD_MASK =
		{relr_pkg::WORD_W{1'b1}} >> (relr_pkg::WORD_W - XLEN);

	logic [relr_pkg::WORD_W-1:0] load_offset_q;
	logic [relr_pkg::WORD_W-1:0] word;

	// Offset register, written whenever a config request arrives
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_offset_q <= '0;
		end else if (cfg.valid) begin
			load_offset_q <= cfg.load_offset;
		end
	end

	// Accept while the queue has room
	assign relr_in.ready = !q_stat.full;
	assign push          = relr_in.valid && relr_in.ready;
	assign word          = relr_in.relr_word & WORD_MASK;

	// Classify: address entries are relocated here, bitmaps drop their tag bit
	always_comb begin
		push_data.last = relr_in.end_of_table;
		if (word[0]) begin
			push_data.kind  = relr_pkg::ENT_BITMAP;
			push_data.value = relr_pkg::WORD_W'(word[XLEN-1:1]);
		end else begin
			push_data.kind  = relr_pkg::ENT_ADDR;
			push_data.value = (word + load_offset_q) & WORD_MASK;
		end
	end

endmodule

// ===== src/relr_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified entries between front and back end.
// Depends on relr_pkg for the entry and status types.
module relr_fifo #(
	parameter int unsigned DEPTH = relr_pkg::FIFO_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  relr_pkg::q_entry_t  push_data,
	input  logic                pop,
	output relr_pkg::q_entry_t  pop_data,
	output relr_pkg::q_stat_t   q_stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	relr_pkg::q_entry_t mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/relr_back.sv =====
`timescale 1ns / 1ps
// Back end: tracks the next place, drives the output register and expands
// bitmaps one bit per cycle while it is free. Uses relr_pkg, relr_out_if.
module relr_back #(
	parameter int unsigned XLEN = relr_pkg::XLEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  relr_pkg::q_stat_t   q_stat,
	input  relr_pkg::q_entry_t  pop_data,
	output logic                pop,
	relr_out_if.source          patch_out
);

	localparam int unsigned W = relr_pkg::WORD_W;
	localparam logic [W-1:0] WORD_MASK  = {W{1'b1}} >> (W - XLEN);
	localparam logic [W-1:0] WORD_BYTES = W'(XLEN / 8);
	localparam logic [W-1:0] RUN_BYTES  = W'((XLEN - 1) * (XLEN / 8));

	relr_pkg::back_state_t state_q, state_d;

	logic [W-1:0]      next_place_q;
	logic [W-1:0]      cur_q;
	logic [XLEN-2:0]   rem_q;
	logic              run_last_q;

	logic              out_valid_q;
	logic [W-1:0]      out_addr_q;
	logic              out_last_q;

	logic              out_free;
	logic              emit;
	logic [W-1:0]      emit_addr;
	logic              emit_last;
	logic              shift;
	logic              run_done;

	assign out_free = !out_valid_q || patch_out.ready;
	assign run_done = (rem_q == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			relr_pkg::BK_IDLE: begin
				if (!q_stat.empty && pop_data.kind == relr_pkg::ENT_BITMAP) begin
					state_d = relr_pkg::BK_SCAN;
				end
			end
			relr_pkg::BK_SCAN: begin
				if (run_done) begin
					state_d = relr_pkg::BK_IDLE;
				end
			end
			default: state_d = relr_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_addr = cur_q;
		emit_last = 1'b0;
		shift     = 1'b0;
		case (state_q)
			relr_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					if (pop_data.kind == relr_pkg::ENT_ADDR) begin
						pop       = out_free;
						emit      = out_free;
						emit_addr = pop_data.value;
						emit_last = 1'b1;
					end else begin
						pop = 1'b1;
					end
				end
			end
			relr_pkg::BK_SCAN: begin
				if (!run_done) begin
					if (rem_q[0]) begin
						emit      = out_free;
						shift     = out_free;
						emit_last = ((rem_q >> 1) == '0);
					end else begin
						shift = 1'b1;
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= relr_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next place tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_place_q <= '0;
		end else if (state_q == relr_pkg::BK_IDLE) begin
			if (pop && pop_data.kind == relr_pkg::ENT_ADDR) begin
				next_place_q <= pop_data.last ? '0 : (pop_data.value + WORD_BYTES) & WORD_MASK;
			end
		end else if (run_done) begin
			next_place_q <= run_last_q ? '0 : (next_place_q + RUN_BYTES) & WORD_MASK;
		end
	end

	// Bitmap scan registers
	always_ff @(posedge clk) begin
		if (state_q == relr_pkg::BK_IDLE) begin
			if (pop && pop_data.kind == relr_pkg::ENT_BITMAP) begin
				rem_q      <= pop_data.value[XLEN-2:0];
				cur_q      <= next_place_q;
				run_last_q <= pop_data.last;
			end
		end else if (shift) begin
			rem_q <= rem_q >> 1;
			cur_q <= (cur_q + WORD_BYTES) & WORD_MASK;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (patch_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q <= emit_addr;
			out_last_q <= emit_last;
		end
	end

	assign patch_out.valid         = out_valid_q;
	assign patch_out.patch_address = out_addr_q;
	assign patch_out.last_of_run   = out_last_q;

endmodule

// ===== src/relr_relocation_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the RELR relocation decoder: front end, entry queue, back end.
// Depends on relr_pkg, the three channel interfaces, relr_front, relr_fifo, relr_back.

// Turns a stream of RELR table words into the byte addresses that need the
// load offset added. The front end takes one word per cycle into a short queue
// while there is room; the back end drains it. An address entry yields one
// address. A bitmap entry is walked one bit per cycle by the back-end scan
// loop, which stalls only while the output register holds a request the
// receiver has not taken. The end-of-table flag clears the running place
// after its entry. Write load_offset only while idle.
module relr_relocation_decoder #(
	parameter int unsigned XLEN       = relr_pkg::XLEN_DEFAULT,
	parameter int unsigned FIFO_DEPTH = relr_pkg::FIFO_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	relr_in_if.sink    relr_in,
	relr_cfg_if.sink   cfg,
	relr_out_if.source patch_out
);

	relr_pkg::q_stat_t  q_stat;
	relr_pkg::q_entry_t push_data;
	relr_pkg::q_entry_t pop_data;
	logic               push;
	logic               pop;

	// Accept and classify
	relr_front #(
		.XLEN (XLEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.relr_in   (relr_in),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue
	relr_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Expand and emit
	relr_back #(
		.XLEN (XLEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.patch_out (patch_out)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for relr_relocation_decoder: drives RELR entries and load offsets,
// predicts every patch address and checks the output stream in order.
// Depends on relr_pkg, relr_in_if, relr_out_if, relr_cfg_if and the decoder RTL.
module tb_top;

	localparam int unsigned WORD_W     = relr_pkg::WORD_W;
	localparam int unsigned XLEN       = relr_pkg::XLEN_DEFAULT;
	localparam logic [WORD_W-1:0] XMASK =
		(XLEN >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << XLEN) - 64'd1);
	localparam logic [WORD_W-1:0] WORD_BYTES = WORD_W'(XLEN / 8);
	localparam int QUIET_CYCLES   = 200;   // drain time for items that emit nothing
	localparam int STALL_LIMIT    = 3000;  // cycles with no request before giving up
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off

	// One expected output request
	typedef struct packed {
		logic [WORD_W-1:0] address;
		logic              last;
	} patch_t;

	// Predicts patch addresses from accepted entries and checks the outputs
	class patch_scoreboard;
		logic [WORD_W-1:0] next_place;
		logic [WORD_W-1:0] load_offset;
		patch_t            pending_patches[$];
		int                mismatch_count;

		function new();
			next_place     = '0;
			load_offset    = '0;
			mismatch_count = 0;
		endfunction

		task report_mismatch(input string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatch_count++;
		endtask

		function void set_offset(input logic [WORD_W-1:0] value);
			load_offset = value;
		endfunction

		// Expand one entry into the addresses it patches
		function void note_entry(input logic [WORD_W-1:0] raw_word, input logic eot);
			logic [WORD_W-1:0] w;
			logic [WORD_W-1:0] off;
			logic [WORD_W-1:0] kk;
			patch_t            p;
			int                top;
			w   = raw_word & XMASK;
			off = load_offset & XMASK;
			if (relr_pkg::entry_kind_t'(w[0]) == relr_pkg::ENT_ADDR) begin
				p.address = (w + off) & XMASK;
				p.last    = 1'b1;
				pending_patches.push_back(p);
				next_place = (p.address + WORD_BYTES) & XMASK;
			end else begin
				top = -1;
				for (int k = 0; k < XLEN - 1; k++)
					if (w[k+1]) top = k;
				for (int k = 0; k < XLEN - 1; k++) begin
					if (w[k+1]) begin
						kk        = WORD_W'(k);
						p.address = (next_place + kk * WORD_BYTES) & XMASK;
						p.last    = (k == top);
						pending_patches.push_back(p);
					end
				end
				next_place = (next_place + (XLEN - 1) * WORD_BYTES) & XMASK;
			end
			if (eot) next_place = '0;
		endfunction

		task check_patch(input logic [WORD_W-1:0] address, input logic last);
			patch_t e;
			if (pending_patches.size() == 0) begin
				report_mismatch($sformatf("unexpected patch address %h", address));
			end else begin
				e = pending_patches.pop_front();
				if (address !== e.address)
					report_mismatch($sformatf("patch_address %h, expected %h",
						address, e.address));
				if (last !== e.last)
					report_mismatch($sformatf("last_of_run %b, expected %b at %h",
						last, e.last, e.address));
			end
		endtask

		function int pending_count();
			return pending_patches.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	relr_in_if  relr_in();
	relr_cfg_if cfg();
	relr_out_if patch_out();

	relr_relocation_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.relr_in   (relr_in),
		.cfg       (cfg),
		.patch_out (patch_out)
	);

	patch_scoreboard sb;
	int send_idle;
	int recv_idle;
	int hold_left;
	int stall_cycles;
	int entries_sent;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: offset writes, accepted entries and accepted addresses
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) sb.set_offset(cfg.load_offset);
			if (relr_in.valid && relr_in.ready)
				sb.note_entry(relr_in.relr_word, relr_in.end_of_table);
			if (patch_out.valid && patch_out.ready)
				sb.check_patch(patch_out.patch_address, patch_out.last_of_run);
		end
	end

	// Receiver: random back-pressure, or a long hold-off when asked
	initial begin
		patch_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				patch_out.ready <= 1'b0;
				hold_left--;
			end else begin
				patch_out.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if ((relr_in.valid && relr_in.ready) || (cfg.valid && cfg.ready) ||
		    (patch_out.valid && patch_out.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Offer one entry, with random idle cycles first
	task automatic send_entry(input logic [WORD_W-1:0] w, input logic eot);
		while ($urandom_range(99) < send_idle) begin
			relr_in.valid <= 1'b0;
			@(posedge clk);
		end
		relr_in.valid        <= 1'b1;
		relr_in.relr_word    <= w;
		relr_in.end_of_table <= eot;
		@(posedge clk);
		while (!relr_in.ready) @(posedge clk);
		entries_sent++;
	endtask

	// Wait for every expected address, then let empty bitmaps drain
	task automatic wait_drained();
		relr_in.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(input logic [WORD_W-1:0] value);
		cfg.valid       <= 1'b1;
		cfg.load_offset <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] rand_address();
		if ($urandom_range(99) < 30)
			return 64'($urandom_range(0, 4096)) * WORD_BYTES;
		return rand_word() & ~64'h1;
	endfunction

	function automatic logic [WORD_W-1:0] rand_bitmap();
		int r;
		logic [WORD_W-1:0] w;
		r = $urandom_range(99);
		if (r < 10) begin
			w = 64'h1;
		end else if (r < 15) begin
			w = {WORD_W{1'b1}};
		end else if (r < 60) begin
			w = 64'h1 | (64'h1 << $urandom_range(1, 63));
			if ($urandom_range(1)) w |= 64'h1 << $urandom_range(1, 63);
		end else begin
			w = rand_word() | 64'h1;
		end
		return w;
	endfunction

	// Mostly well-formed tables: an address, a few bitmaps, maybe an end mark
	task automatic send_random(input int count);
		int stop_at;
		int nbm;
		stop_at = entries_sent + count;
		while (entries_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				// noise: a lone entry of either kind
				if ($urandom_range(1)) send_entry(rand_bitmap(), $urandom_range(99) < 30);
				else send_entry(rand_address(), $urandom_range(99) < 30);
			end else begin
				nbm = $urandom_range(0, 4);
				send_entry(rand_address(), (nbm == 0) && $urandom_range(1));
				for (int i = 0; i < nbm; i++)
					send_entry(rand_bitmap(), (i == nbm - 1) && $urandom_range(1));
			end
		end
	endtask

	task automatic send_directed();
		send_entry(64'h3, 1'b0);                    // bitmap before any address
		send_entry(64'h1, 1'b0);                    // empty bitmap still advances
		send_entry(64'h5, 1'b0);
		send_entry(64'h0, 1'b0);
		send_entry({WORD_W{1'b1}}, 1'b0);           // every bitmap bit set
		send_entry(64'h8000_0000_0000_0001, 1'b0);  // top bit only
		send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);  // address wraps with offset
		send_entry(64'h3, 1'b0);                    // bitmap after the wrapped address
		send_entry(64'h1234_5678_9ABC_DEF0, 1'b1);  // end of table on an address
		send_entry(64'h7, 1'b0);                    // after end of table
		send_entry(64'h1, 1'b1);                    // end of table on an empty bitmap
		send_entry(64'h8, 1'b0);
		send_entry(64'hAAAA_AAAA_AAAA_AAAB, 1'b1);  // end of table on a bitmap
		send_entry(64'h5555_5555_5555_5555, 1'b0);
		send_entry(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
		send_entry(64'h0, 1'b1);
	endtask

	// Main sequence
	initial begin
		sb           = new();
		send_idle    = 37;
		recv_idle    = 48;
		hold_left    = 0;
		stall_cycles = 0;
		entries_sent = 0;
		arst_n               <= 1'b0;
		relr_in.valid        <= 1'b0;
		relr_in.relr_word    <= '0;
		relr_in.end_of_table <= 1'b0;
		cfg.valid            <= 1'b0;
		cfg.load_offset      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed entries under a small offset
		write_offset(64'h0000_0000_0001_0000);
		send_directed();
		wait_drained();

		// Largest offset
		write_offset({WORD_W{1'b1}});
		send_entry(64'h0, 1'b0);
		send_entry(64'h3, 1'b1);
		send_random(40);
		wait_drained();

		// Random offset, idling swapped
		send_idle = 48;
		recv_idle = 37;
		write_offset(rand_word());
		send_random(40);
		wait_drained();

		// No idling; receiver holds off while dense bitmaps pile up
		send_idle = 0;
		recv_idle = 0;
		write_offset(64'h0);
		hold_left = HOLD_CYCLES;
		send_entry(64'h100, 1'b0);
		repeat (6) send_entry({WORD_W{1'b1}}, 1'b0);
		// sender pauses until the backlog is gone
		relr_in.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		send_random(30);
		wait_drained();

		if (sb.pending_count() != 0)
			sb.report_mismatch($sformatf("%0d addresses never came", sb.pending_count()));
		if (sb.mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
